[sv/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types and codes shared by the multilevel feedback queue lock arbiter.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    // request commands
    localparam logic [1:0] CMD_LOCK   = 2'd0;
    localparam logic [1:0] CMD_UNLOCK = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_QUEUED  = 3'd1;
    localparam logic [2:0] ST_HANDOFF = 3'd2;
    localparam logic [2:0] ST_FREED   = 3'd3;
    localparam logic [2:0] ST_TICK    = 3'd4;
    localparam logic [2:0] ST_UNLKERR = 3'd5;

    // configuration register indexes
    localparam logic CFG_QUANTUM = 1'b0;
    localparam logic CFG_LEVELS  = 1'b1;

    // configuration reset values
    localparam logic [15:0] QUANTUM_RESET = 16'd1000;
    localparam logic [3:0]  LEVELS_RESET  = 4'd8;

    // divider length (hold timer width)
    localparam int TIMER_W = 32;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] woken_thread;
        logic [2:0] level;
        logic       lock_held;
    } rsp_t;

    // controller to datapath strobes
    typedef struct packed {
        logic latch_in;
        logic exec;
        logic div_start;
        logic div_step;
        logic scan;
        logic wake;
        logic load_out;
    } ctrl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_unlock;
        logic busy;
        logic div_last;
        logic any_waiting;
        logic out_free;
    } ctrl_sts_t;

endpackage

[sv/mlfq_ctrl.sv]
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: fetch, execute, divide, scan, wake and result hand-over.
// ----------------------------------------------------------------------------
module mlfq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  mlfq_pkg::ctrl_sts_t sts,
    output mlfq_pkg::ctrl_cmd_t cmd
);
    import mlfq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FETCH  = 7'b0000010,
        S_EXEC   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_SCAN   = 7'b0010000,
        S_WAKE   = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_FETCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (sts.is_unlock && sts.busy)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_RESULT;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = sts.any_waiting ? S_WAKE : S_RESULT;
            end
            S_WAKE:
            begin
                cmd.wake   = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/mlfq_dp.sv]
// ----------------------------------------------------------------------------
// mlfq_dp
// Datapath: lock state, hold timer, level table, level queues, divider and
// result register.
// ----------------------------------------------------------------------------
module mlfq_dp #(
    parameter int THREADS = 16,
    parameter int LEVELS  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  mlfq_pkg::req_t      cmd_item,
    output logic                res_valid,
    input  logic                res_stall,
    output mlfq_pkg::rsp_t      res_item,
    input  mlfq_pkg::ctrl_cmd_t cmd,
    output mlfq_pkg::ctrl_sts_t sts
);
    import mlfq_pkg::*;

    localparam int TW = $clog2(THREADS);
    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CW = $clog2(THREADS + 1);
    localparam int AW = $clog2(LEVELS * THREADS);
    localparam int DCW = $clog2(TIMER_W);

    // configuration
    logic [15:0] quantum_reg;
    logic [3:0]  levels_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= QUANTUM_RESET;
            levels_reg  <= LEVELS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_QUANTUM: quantum_reg <= cfg_data;
                CFG_LEVELS:  levels_reg  <= cfg_data[3:0];
                default:     quantum_reg <= quantum_reg;
            endcase
        end
    end

    // last level in use
    logic [LW-1:0] last_lvl;
    always_comb
    begin
        if (levels_reg == 4'd0)
        begin
            last_lvl = '0;
        end
        else if (6'(levels_reg) > 6'(LEVELS))
        begin
            last_lvl = LW'(LEVELS - 1);
        end
        else
        begin
            last_lvl = LW'(levels_reg - 4'd1);
        end
    end

    // latched request
    logic [1:0]    op_reg;
    logic [TW-1:0] tid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg  <= cmd_item.command;
            tid_reg <= TW'(cmd_item.thread_id % THREADS);
        end
    end

    // lock state and hold timer registers
    logic               busy_reg;
    logic [TIMER_W-1:0] timer_reg;

    // thread level table: memory plus reset-cleared valid bits
    logic [LW-1:0]      tbl_mem [THREADS];
    logic [LW-1:0]      tbl_rdata;
    logic [THREADS-1:0] tbl_valid_reg;
    logic [LW-1:0]      tbl_level;
    logic [LW-1:0]      new_lvl;

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            tbl_mem[tid_reg] <= new_lvl;
        end
        tbl_rdata <= tbl_mem[tid_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (cmd.scan)
        begin
            tbl_valid_reg[tid_reg] <= 1'b1;
        end
    end

    assign tbl_level = tbl_valid_reg[tid_reg] ? tbl_rdata : '0;

    // level queue pointers and counts
    logic [TW-1:0] head_reg  [LEVELS];
    logic [TW-1:0] tail_reg  [LEVELS];
    logic [CW-1:0] count_reg [LEVELS];

    // enqueue level and wake level
    logic [LW-1:0]  q_lvl;
    logic [LW-1:0]  found_lvl;
    logic           any_waiting;
    logic           enq;
    logic [TW-1:0]  tail_cur;
    logic [TW-1:0]  head_cur;

    assign q_lvl    = (tbl_level > last_lvl) ? last_lvl : tbl_level;
    assign tail_cur = tail_reg[q_lvl];
    assign head_cur = head_reg[found_lvl];
    assign enq      = cmd.exec && (op_reg == CMD_LOCK) && busy_reg &&
                      (count_reg[q_lvl] < CW'(THREADS));

    // first non-empty level
    always_comb
    begin
        found_lvl   = '0;
        any_waiting = 1'b0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (count_reg[i] != '0)
            begin
                found_lvl   = LW'(i);
                any_waiting = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (enq)
        begin
            tail_reg[q_lvl]  <= (32'(tail_cur) == THREADS - 1) ? '0 : tail_cur + 1'b1;
            count_reg[q_lvl] <= count_reg[q_lvl] + 1'b1;
        end
        else if (cmd.scan && any_waiting)
        begin
            head_reg[found_lvl]  <= (32'(head_cur) == THREADS - 1) ? '0 : head_cur + 1'b1;
            count_reg[found_lvl] <= count_reg[found_lvl] - 1'b1;
        end
    end

    // queue store
    logic [TW-1:0] store_mem [LEVELS * THREADS];
    logic [TW-1:0] store_rdata;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    assign wr_addr = AW'(AW'(q_lvl) * AW'(THREADS) + AW'(tail_cur));
    assign rd_addr = AW'(AW'(found_lvl) * AW'(THREADS) + AW'(head_cur));

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            store_mem[wr_addr] <= tid_reg;
        end
        store_rdata <= store_mem[rd_addr];
    end

    // restoring divider: hold timer / quantum
    logic [TIMER_W-1:0] qd_reg;
    logic [15:0]        rem_reg;
    logic [DCW-1:0]     dcnt_reg;
    logic [15:0]        divisor;
    logic [16:0]        trial;
    logic               fits;

    assign divisor = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign trial   = {rem_reg, qd_reg[TIMER_W-1]};
    assign fits    = (trial >= {1'b0, divisor});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            qd_reg   <= timer_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            qd_reg   <= {qd_reg[TIMER_W-2:0], fits};
            rem_reg  <= fits ? 16'(trial - {1'b0, divisor}) : trial[15:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // releaser's new level, saturating at the last level in use
    logic [LW-1:0] lvl_room;
    always_comb
    begin
        lvl_room = last_lvl - tbl_level;
        if (tbl_level > last_lvl)
        begin
            new_lvl = last_lvl;
        end
        else if (qd_reg >= TIMER_W'(lvl_room))
        begin
            new_lvl = last_lvl;
        end
        else
        begin
            new_lvl = tbl_level + LW'(qd_reg);
        end
    end

    // lock state and hold timer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            timer_reg <= '0;
        end
        else if (cmd.exec && (op_reg == CMD_LOCK) && !busy_reg)
        begin
            busy_reg  <= 1'b1;
            timer_reg <= '0;
        end
        else if (cmd.exec && (op_reg == CMD_TICK) && (timer_reg != '1))
        begin
            timer_reg <= timer_reg + 1'b1;
        end
        else if (cmd.scan)
        begin
            if (any_waiting)
            begin
                timer_reg <= '0;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // pending result
    logic [2:0]    rs_status_reg;
    logic [TW-1:0] rs_woken_reg;
    logic [LW-1:0] rs_level_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rs_woken_reg <= '0;
            rs_level_reg <= '0;
            priority if (op_reg == CMD_LOCK)
            begin
                rs_status_reg <= busy_reg ? ST_QUEUED : ST_GRANTED;
                rs_level_reg  <= busy_reg ? q_lvl : '0;
            end
            else if (op_reg == CMD_UNLOCK)
            begin
                rs_status_reg <= ST_UNLKERR;
            end
            else
            begin
                rs_status_reg <= ST_TICK;
            end
        end
        else if (cmd.scan)
        begin
            rs_status_reg <= any_waiting ? ST_HANDOFF : ST_FREED;
            rs_woken_reg  <= '0;
            rs_level_reg  <= new_lvl;
        end
        else if (cmd.wake)
        begin
            rs_woken_reg <= store_rdata;
        end
    end

    // output register
    logic res_valid_reg;
    rsp_t res_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_item_reg.status       <= rs_status_reg;
            res_item_reg.woken_thread <= 4'(rs_woken_reg);
            res_item_reg.level        <= 3'(rs_level_reg);
            res_item_reg.lock_held    <= busy_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // status to the sequencer
    assign sts.is_unlock   = (op_reg == CMD_UNLOCK);
    assign sts.busy        = busy_reg;
    assign sts.div_last    = (dcnt_reg == DCW'(TIMER_W - 1));
    assign sts.any_waiting = any_waiting;
    assign sts.out_free    = !res_valid_reg || !res_stall;

`ifndef SYNTH
    a_handoff_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.status == ST_HANDOFF) |-> res_item.lock_held)
        else $error("hand-off result with lock free");
    a_freed_free: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_item.status == ST_FREED) |-> !res_item.lock_held)
        else $error("freed result with lock held");
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && op_reg == CMD_LOCK && !busy_reg) |=> busy_reg)
        else $error("grant did not take the lock");
    a_no_enq_free: assert property (@(posedge clk) disable iff (!rst_n)
        enq |-> busy_reg)
        else $error("enqueue while lock free");
`endif

endmodule

[sv/mlfq_lock_arbiter.sv]
// ----------------------------------------------------------------------------
// mlfq_lock_arbiter
// Lock manager with multilevel feedback queues.
// ----------------------------------------------------------------------------
// One request is handled at a time. A lock request, a tick or an unlock of a
// free lock passes through fetch and execute to the result state; an unlock
// of a held lock instead runs the bit-serial divider (32 steps) that divides
// the hold timer by the quantum, then the scan and, when it hands the lock
// off, a wake before the result state.
// The result register lets a new request be accepted while the last result
// still waits to be taken. No clearing pass follows reset.
module mlfq_lock_arbiter #(
    parameter int THREADS = 16,
    parameter int LEVELS  = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_write,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  mlfq_pkg::req_t cmd_item,
    output logic           res_valid,
    input  logic           res_stall,
    output mlfq_pkg::rsp_t res_item
);
    import mlfq_pkg::*;

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .cmd       (ctl)
    );

    mlfq_dp #(
        .THREADS (THREADS),
        .LEVELS  (LEVELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cmd       (ctl),
        .sts       (sts)
    );

endmodule

[sim/mlfq_lock_arbiter_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mlfq_lock_arbiter_tb
// Self-checking bench: drives lock, unlock, tick and unused-code requests with random
// gaps and stalls, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module mlfq_lock_arbiter_tb;
    import mlfq_pkg::*;

    // Scoreboard: lock state model plus queue of expected results
    class lock_scoreboard;
        localparam int NTHR = 16;
        localparam int NLVL = 8;

        logic [15:0] quantum;
        logic [3:0]  levels;
        bit          busy;
        logic [31:0] hold;
        logic [2:0]  thread_lvl [NTHR];
        logic [3:0]  fifo_mem [NLVL][NTHR];
        int          head [NLVL];
        int          tail [NLVL];
        int          count [NLVL];
        rsp_t        pending [$];
        int          errors;

        function new();
            quantum = QUANTUM_RESET;
            levels  = LEVELS_RESET;
            busy    = 0;
            hold    = 0;
            errors  = 0;
            for (int t = 0; t < NTHR; t++) thread_lvl[t] = 0;
            for (int l = 0; l < NLVL; l++)
            begin
                head[l] = 0; tail[l] = 0; count[l] = 0;
                for (int t = 0; t < NTHR; t++) fifo_mem[l][t] = 0;
            end
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == CFG_QUANTUM) quantum = val;
            else levels = val[3:0];
        endfunction

        function int last_level();
            if (levels == 0) return 0;
            if (levels > NLVL) return NLVL - 1;
            return levels - 1;
        endfunction

        // note an accepted request and compute its result
        function void note_request(req_t rq);
            rsp_t  r;
            int    last;
            int    lv;
            longint nl;
            int    q;
            bit    found;
            last = last_level();
            r = '0;
            found = 0;
            case (rq.command)
                CMD_LOCK:
                begin
                    if (!busy)
                    begin
                        busy = 1; hold = 0; r.status = ST_GRANTED;
                    end
                    else
                    begin
                        lv = thread_lvl[rq.thread_id];
                        if (lv > last) lv = last;
                        if (count[lv] < NTHR)
                        begin
                            fifo_mem[lv][tail[lv]] = rq.thread_id;
                            tail[lv] = (tail[lv] + 1) % NTHR;
                            count[lv]++;
                        end
                        r.status = ST_QUEUED;
                        r.level  = 3'(lv);
                    end
                end
                CMD_UNLOCK:
                begin
                    if (!busy) r.status = ST_UNLKERR;
                    else
                    begin
                        q  = (quantum == 0) ? 1 : quantum;
                        nl = longint'(thread_lvl[rq.thread_id]) + longint'(hold / q);
                        if (nl > last) nl = last;
                        thread_lvl[rq.thread_id] = 3'(nl);
                        r.level = 3'(nl);
                        for (int l = 0; l < NLVL && !found; l++)
                        begin
                            if (count[l] != 0)
                            begin
                                r.woken_thread = fifo_mem[l][head[l]];
                                head[l] = (head[l] + 1) % NTHR;
                                count[l]--;
                                hold = 0;
                                found = 1;
                            end
                        end
                        if (found) r.status = ST_HANDOFF;
                        else
                        begin
                            busy = 0; r.status = ST_FREED;
                        end
                    end
                end
                default:
                begin
                    if (rq.command == CMD_TICK && hold != 32'hFFFF_FFFF) hold++;
                    r.status = ST_TICK;
                end
            endcase
            r.lock_held = busy;
            pending.push_back(r);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result");
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status) report("status mismatch");
            if (got.woken_thread !== want.woken_thread) report("woken_thread mismatch");
            if (got.level !== want.level) report("level mismatch");
            if (got.lock_held !== want.lock_held) report("lock_held mismatch");
        endfunction

        function void report(string what);
            $display("ERROR %0t: %s", $time, what);
            errors++;
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        cmd_valid;
    logic        cmd_stall;
    req_t        cmd_item;
    logic        res_valid;
    logic        res_stall;
    rsp_t        res_item;

    lock_scoreboard sb;
    longint cycles;
    bit     sending_done;

    mlfq_lock_arbiter uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd_item(cmd_item),
        .res_valid(res_valid), .res_stall(res_stall), .res_item(res_item)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // timeout guard
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2_000_000)
            begin
                $display("mlfq_lock_arbiter test failed");
                $finish;
            end
        end
    end

    // result side: draw a wait per result, then take it
    initial
    begin
        int wait_n;
        res_stall = 1'b1;
        forever
        begin
            wait_n = sending_done ? 0 : int'($urandom_range(0, 4));
            repeat (wait_n) @(negedge clk);
            @(negedge clk);
            res_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && res_valid));
            @(negedge clk);
            res_stall <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall) sb.check_result(res_item);
    end

    // send one request with a random gap in front
    task automatic send_request(logic [1:0] c, logic [3:0] t);
        req_t rq;
        int   gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 4));
        rq.command   = c;
        rq.thread_id = t;
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_item  <= rq;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (cmd_stall);
        sb.note_request(rq);
        @(negedge clk);
    endtask

    // wait until every expected result is in, then let the block settle
    task automatic drain();
        cmd_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_write <= 1'b1;
        @(negedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    // random phase: mostly lock/tick/unlock sequences, some noise
    task automatic random_phase(int n, int max_ticks);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 4) send_request(CMD_LOCK, 4'($urandom_range(0, 15)));
            else if (k < 6) send_request(CMD_UNLOCK, 4'($urandom_range(0, 15)));
            else if (k < 9)
                repeat ($urandom_range(1, max_ticks)) send_request(CMD_TICK, 4'd0);
            else send_request(2'd3, 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        sb = new();
        sending_done = 0;
        rst_n = 0;
        cfg_write = 0; cfg_index = 0; cfg_data = 0;
        cmd_valid = 0; cmd_item = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: unlock while free, grant, queue, ticks, handoff, free
        write_reg(CFG_QUANTUM, 16'd2);
        send_request(CMD_UNLOCK, 4'd0);
        send_request(CMD_LOCK, 4'd0);
        send_request(CMD_LOCK, 4'd15);
        send_request(CMD_LOCK, 4'd5);
        repeat (7) send_request(CMD_TICK, 4'd9);
        send_request(2'd3, 4'd15);
        send_request(CMD_UNLOCK, 4'd0);
        send_request(CMD_UNLOCK, 4'd15);
        send_request(CMD_UNLOCK, 4'd5);
        send_request(CMD_UNLOCK, 4'd5);
        send_request(CMD_LOCK, 4'd0);
        send_request(CMD_LOCK, 4'd0);
        send_request(CMD_UNLOCK, 4'd3);
        send_request(CMD_UNLOCK, 4'd0);
        drain();

        // queue overflow at one level, then release all
        write_reg(CFG_LEVELS, 16'd0);
        send_request(CMD_LOCK, 4'd1);
        for (int i = 0; i < 18; i++) send_request(CMD_LOCK, i[3:0]);
        for (int i = 0; i < 17; i++) send_request(CMD_UNLOCK, i[3:0]);
        drain();

        // random phases over several settings
        write_reg(CFG_QUANTUM, 16'd0);
        write_reg(CFG_LEVELS, 16'd15);
        random_phase(60, 4);
        drain();
        write_reg(CFG_QUANTUM, 16'd1);
        write_reg(CFG_LEVELS, 16'd3);
        random_phase(60, 4);
        drain();
        write_reg(CFG_QUANTUM, 16'hFFFF);
        write_reg(CFG_LEVELS, 16'd8);
        random_phase(50, 4);
        drain();
        write_reg(CFG_QUANTUM, 16'h8001);
        write_reg(CFG_LEVELS, 16'd1);
        random_phase(40, 4);
        drain();
        write_reg(CFG_QUANTUM, 16'd3);
        write_reg(CFG_LEVELS, 16'd5);
        random_phase(60, 12);
        drain();
        write_reg(CFG_QUANTUM, 16'($urandom_range(1, 6)));
        write_reg(CFG_LEVELS, 16'($urandom_range(0, 15)));
        random_phase(150, 6);
        drain();

        sending_done = 1;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("mlfq_lock_arbiter test passed");
        else
            $display("mlfq_lock_arbiter test failed");
        $finish;
    end
endmodule
